// ===== hw/rtl/dspmbx_pkg.sv =====
// shared types and constants for the dsp mailbox / dma register page
package dspmbx_pkg;

  // operation carried on the input tuser
  typedef enum logic [2:0] {
    OpDspRead     = 3'd0,
    OpDspWrite    = 3'd1,
    OpCpuWrMboxHi = 3'd2,
    OpCpuWrMboxLo = 3'd3,
    OpCpuRdCmbHi  = 3'd4,
    OpCpuRdDmbHi  = 3'd5,
    OpCpuRdDmbLo  = 3'd6,
    OpReset       = 3'd7
  } op_t;

  // dense register numbers on the dsp side
  localparam logic [5:0] RegDsmah     = 6'd0;
  localparam logic [5:0] RegDsmal     = 6'd1;
  localparam logic [5:0] RegDspa      = 6'd2;
  localparam logic [5:0] RegDscr      = 6'd3;
  localparam logic [5:0] RegDsbl      = 6'd4;
  localparam logic [5:0] RegCmbh      = 6'd5;
  localparam logic [5:0] RegCmbl      = 6'd6;
  localparam logic [5:0] RegDmbh      = 6'd7;
  localparam logic [5:0] RegDmbl      = 6'd8;
  localparam logic [5:0] RegDirq      = 6'd9;
  localparam logic [5:0] RegAccFirst  = 6'd10;
  localparam logic [5:0] RegAccLast   = 6'd20;
  localparam logic [5:0] RegAcdat2    = 6'd21;
  localparam logic [5:0] RegAcdat     = 6'd22;
  localparam logic [5:0] RegCoefFirst = 6'd23;
  localparam logic [5:0] RegCoefLast  = 6'd38;
  localparam logic [5:0] RegSink0     = 6'd39;
  localparam logic [5:0] RegSink1     = 6'd40;

  localparam int unsigned AccCount  = 11;
  localparam int unsigned CoefCount = 16;

  // store masks
  localparam logic [15:0] ValidBit     = 16'h8000;
  localparam logic [15:0] MainHighMask = 16'h03ff;
  localparam logic [15:0] WordMask     = 16'hfffc; // ~3
  localparam logic [15:0] HalfMask     = 16'hfffe; // ~1

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 80;

endpackage

// ===== hw/rtl/dsp_mailbox_dma_register_port.sv =====
// dsp hardware register page: mailboxes, dma registers, irq request, accelerator storage
//
// one beat in on the s_axis side is one register bus access; one beat out on
// the m_axis side is its result. the operation travels on s_axis_tuser, the
// register number and write data on s_axis_tdata.
// every access is decoded and applied to the register page in the cycle it is
// accepted, and its result lands in the output register, valid in the next cycle;
// one access is taken per cycle while the receiver does not stall.
// the output register is the only buffering; when the receiver stalls,
// s_axis_tready drops until the waiting result is taken, and taking the result
// frees room for a new beat in the same cycle.
// dma_start and cpu_interrupt are single-beat pulses; the dma fields read zero
// on every beat that is not a block-size write.
// rst (synchronous, active high) clears every register of the page and empties
// the output register; the reset operation clears the page too and returns
// an all-zero result beat.
// the dma copy itself and the dsp memories live outside this block.
module dsp_mailbox_dma_register_port (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_index [5:0], write_value [21:6], zero [23:22]
  input  logic [23:0] s_axis_tdata,
  // op [2:0]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_data [15:0], access_error [16], dma_start [17], dma_main_address [43:18],
  // dma_local_address [59:44], dma_length [75:60], dma_mode [77:76],
  // cpu_interrupt [78], zero [79]
  output logic [79:0] m_axis_tdata
);

  // register page state
  logic [9:0]  dma_main_high;
  logic [15:0] dma_main_low;
  logic [15:0] dma_local_addr;
  logic [1:0]  dma_control_bits;
  logic [15:0] dma_block_size;
  logic [15:0] cpu_mbox_shadow;
  logic [15:0] cpu_mbox_hi;
  logic [15:0] cpu_mbox_lo;
  logic [15:0] dsp_mbox_shadow;
  logic [15:0] dsp_mbox_hi;
  logic [15:0] dsp_mbox_lo;
  logic [15:0] accel_registers [dspmbx_pkg::AccCount];
  logic [15:0] decoder_coefficients [dspmbx_pkg::CoefCount];

  // unpacked input beat
  dspmbx_pkg::op_t op;
  logic [5:0]      reg_index;
  logic [15:0]     write_value;
  logic            accept;

  assign op          = dspmbx_pkg::op_t'(s_axis_tuser);
  assign reg_index   = s_axis_tdata[5:0];
  assign write_value = s_axis_tdata[21:6];

  // room when the output register is empty or is being drained this cycle
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // register class decode
  logic       is_acc;
  logic       is_coef;
  logic [3:0] acc_idx;
  logic [3:0] coef_idx;

  assign is_acc   = (reg_index >= dspmbx_pkg::RegAccFirst) &&
                    (reg_index <= dspmbx_pkg::RegAccLast);
  assign is_coef  = (reg_index >= dspmbx_pkg::RegCoefFirst) &&
                    (reg_index <= dspmbx_pkg::RegCoefLast);
  assign acc_idx  = 4'(reg_index - dspmbx_pkg::RegAccFirst);
  assign coef_idx = 4'(reg_index - dspmbx_pkg::RegCoefFirst);

  // result of the current beat
  logic [15:0] read_data;
  logic        access_error;
  logic        dma_start;
  logic        cpu_interrupt;
  logic [15:0] dma_length;

  always_comb begin
    read_data     = '0;
    access_error  = 1'b0;
    dma_start     = 1'b0;
    cpu_interrupt = 1'b0;
    dma_length    = write_value & dspmbx_pkg::WordMask;
    unique case (op)
      dspmbx_pkg::OpDspRead: begin
        if (is_acc) begin
          read_data = accel_registers[acc_idx];
        end else begin
          priority case (reg_index)
            dspmbx_pkg::RegDsmah:  read_data = {6'd0, dma_main_high};
            dspmbx_pkg::RegDsmal:  read_data = dma_main_low;
            dspmbx_pkg::RegDspa:   read_data = dma_local_addr;
            dspmbx_pkg::RegDscr:   read_data = {14'd0, dma_control_bits};
            dspmbx_pkg::RegDsbl:   read_data = dma_block_size;
            dspmbx_pkg::RegCmbh:   read_data = cpu_mbox_hi;
            dspmbx_pkg::RegCmbl:   read_data = cpu_mbox_lo;
            dspmbx_pkg::RegDmbh:   read_data = dsp_mbox_hi;
            dspmbx_pkg::RegDmbl:   read_data = dsp_mbox_lo;
            // irq request and data ports read as zero
            dspmbx_pkg::RegDirq,
            dspmbx_pkg::RegAcdat2,
            dspmbx_pkg::RegAcdat:  read_data = '0;
            // coefficients, sinks and unknown numbers are not readable
            default:               access_error = 1'b1;
          endcase
        end
      end
      dspmbx_pkg::OpDspWrite: begin
        if (!is_acc && !is_coef) begin
          priority case (reg_index)
            dspmbx_pkg::RegDsmah,
            dspmbx_pkg::RegDsmal,
            dspmbx_pkg::RegDspa,
            dspmbx_pkg::RegDscr,
            dspmbx_pkg::RegDmbh,
            dspmbx_pkg::RegDmbl,
            dspmbx_pkg::RegAcdat2,
            dspmbx_pkg::RegSink0,
            dspmbx_pkg::RegSink1:  access_error = 1'b0;
            dspmbx_pkg::RegDsbl:   dma_start = 1'b1;
            dspmbx_pkg::RegDirq:   cpu_interrupt = write_value[0];
            // cpu mailbox, decoded data port and unknown numbers
            default:               access_error = 1'b1;
          endcase
        end
      end
      dspmbx_pkg::OpCpuRdCmbHi: read_data = cpu_mbox_hi;
      dspmbx_pkg::OpCpuRdDmbHi: read_data = dsp_mbox_hi;
      dspmbx_pkg::OpCpuRdDmbLo: read_data = dsp_mbox_lo;
      dspmbx_pkg::OpCpuWrMboxHi,
      dspmbx_pkg::OpCpuWrMboxLo,
      dspmbx_pkg::OpReset: read_data = '0;
      default: read_data = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid    <= 1'b0;
      dma_main_high    <= '0;
      dma_main_low     <= '0;
      dma_local_addr   <= '0;
      dma_control_bits <= '0;
      dma_block_size   <= '0;
      cpu_mbox_shadow  <= '0;
      cpu_mbox_hi      <= '0;
      cpu_mbox_lo      <= '0;
      dsp_mbox_shadow  <= '0;
      dsp_mbox_hi      <= '0;
      dsp_mbox_lo      <= '0;
      for (int i = 0; i < dspmbx_pkg::AccCount; i++) begin
        accel_registers[i] <= '0;
      end
      for (int i = 0; i < dspmbx_pkg::CoefCount; i++) begin
        decoder_coefficients[i] <= '0;
      end
    end else begin
      if (accept) begin
        m_axis_tvalid <= 1'b1;
        // result beat; dma fields only on a block-size write
        m_axis_tdata[15:0]  <= read_data;
        m_axis_tdata[16]    <= access_error;
        m_axis_tdata[17]    <= dma_start;
        m_axis_tdata[43:18] <= dma_start ? {dma_main_high, dma_main_low} : 26'd0;
        m_axis_tdata[59:44] <= dma_start ? dma_local_addr : 16'd0;
        m_axis_tdata[75:60] <= dma_start ? dma_length : 16'd0;
        m_axis_tdata[77:76] <= dma_start ? dma_control_bits : 2'd0;
        m_axis_tdata[78]    <= cpu_interrupt;
        m_axis_tdata[79]    <= 1'b0;

        unique case (op)
          dspmbx_pkg::OpDspRead: begin
            // reading a low mailbox word clears the valid bit of its high word
            if (reg_index == dspmbx_pkg::RegCmbl) begin
              cpu_mbox_hi <= cpu_mbox_hi & ~dspmbx_pkg::ValidBit;
            end
            if (reg_index == dspmbx_pkg::RegDmbl) begin
              dsp_mbox_hi <= dsp_mbox_hi & ~dspmbx_pkg::ValidBit;
            end
          end
          dspmbx_pkg::OpDspWrite: begin
            if (is_acc) begin
              accel_registers[acc_idx] <= write_value;
            end else if (is_coef) begin
              decoder_coefficients[coef_idx] <= write_value;
            end else begin
              priority case (reg_index)
                dspmbx_pkg::RegDsmah:
                  dma_main_high <= 10'(write_value & dspmbx_pkg::MainHighMask);
                dspmbx_pkg::RegDsmal:
                  dma_main_low <= write_value & dspmbx_pkg::WordMask;
                dspmbx_pkg::RegDspa:
                  dma_local_addr <= write_value & dspmbx_pkg::HalfMask;
                dspmbx_pkg::RegDscr:
                  dma_control_bits <= write_value[1:0];
                dspmbx_pkg::RegDsbl:
                  dma_block_size <= dma_length;
                dspmbx_pkg::RegDmbh:
                  dsp_mbox_shadow <= write_value;
                dspmbx_pkg::RegDmbl: begin
                  dsp_mbox_lo <= write_value;
                  dsp_mbox_hi <= dsp_mbox_shadow | dspmbx_pkg::ValidBit;
                end
                default: ;
              endcase
            end
          end
          dspmbx_pkg::OpCpuWrMboxHi: cpu_mbox_shadow <= write_value;
          dspmbx_pkg::OpCpuWrMboxLo: begin
            cpu_mbox_lo <= write_value;
            cpu_mbox_hi <= cpu_mbox_shadow | dspmbx_pkg::ValidBit;
          end
          dspmbx_pkg::OpCpuRdDmbLo: dsp_mbox_hi <= dsp_mbox_hi & ~dspmbx_pkg::ValidBit;
          dspmbx_pkg::OpReset: begin
            dma_main_high    <= '0;
            dma_main_low     <= '0;
            dma_local_addr   <= '0;
            dma_control_bits <= '0;
            dma_block_size   <= '0;
            cpu_mbox_shadow  <= '0;
            cpu_mbox_hi      <= '0;
            cpu_mbox_lo      <= '0;
            dsp_mbox_shadow  <= '0;
            dsp_mbox_hi      <= '0;
            dsp_mbox_lo      <= '0;
            for (int i = 0; i < dspmbx_pkg::AccCount; i++) begin
              accel_registers[i] <= '0;
            end
            for (int i = 0; i < dspmbx_pkg::CoefCount; i++) begin
              decoder_coefficients[i] <= '0;
            end
          end
          dspmbx_pkg::OpCpuRdCmbHi,
          dspmbx_pkg::OpCpuRdDmbHi: ;
          default: ;
        endcase
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== bench/dsp_mailbox_dma_register_port_tb.sv =====
// self-checking testbench for the dsp mailbox / dma register page
module dsp_mailbox_dma_register_port_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one access in, one result out, the result valid in the cycle after acceptance
  localparam int unsigned PageLatency = 1;

  // result beat as it sits in m_axis_tdata[78:0], read_data in the lowest bits
  typedef struct packed {
    logic        cpu_interrupt;
    logic [1:0]  dma_mode;
    logic [15:0] dma_length;
    logic [15:0] dma_local_address;
    logic [25:0] dma_main_address;
    logic        dma_start;
    logic        access_error;
    logic [15:0] read_data;
  } page_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  // idle and stall odds in percent, changed only while the page is drained
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;

  // results still owed by the page, oldest first
  page_result_t owed_results[$];

  // our own copy of the register page
  logic [9:0]  dma_main_hi;
  logic [15:0] dma_main_lo;
  logic [15:0] dma_local;
  logic [1:0]  dma_ctl;
  logic [15:0] dma_size;
  logic [15:0] cmb_shadow;
  logic [15:0] cmb_hi;
  logic [15:0] cmb_lo;
  logic [15:0] dmb_shadow;
  logic [15:0] dmb_hi;
  logic [15:0] dmb_lo;
  logic [15:0] acc_regs[dspmbx_pkg::AccCount];

  dsp_mailbox_dma_register_port DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // everything on the page back to zero, both after rst and on the reset op
  function automatic void clear_page();
    dma_main_hi = '0;
    dma_main_lo = '0;
    dma_local   = '0;
    dma_ctl     = '0;
    dma_size    = '0;
    cmb_shadow  = '0;
    cmb_hi      = '0;
    cmb_lo      = '0;
    dmb_shadow  = '0;
    dmb_hi      = '0;
    dmb_lo      = '0;
    foreach (acc_regs[i]) acc_regs[i] = '0;
  endfunction

  // applies one access to our page copy and returns the beat it should produce
  function automatic page_result_t apply_access(dspmbx_pkg::op_t op, logic [5:0] idx,
                                                logic [15:0] val);
    page_result_t res;
    res = '0;
    case (op)
      dspmbx_pkg::OpDspRead: begin
        if (idx >= dspmbx_pkg::RegAccFirst && idx <= dspmbx_pkg::RegAccLast) begin
          res.read_data = acc_regs[4'(idx - dspmbx_pkg::RegAccFirst)];
        end else begin
          case (idx)
            dspmbx_pkg::RegDsmah: res.read_data = {6'b0, dma_main_hi};
            dspmbx_pkg::RegDsmal: res.read_data = dma_main_lo;
            dspmbx_pkg::RegDspa:  res.read_data = dma_local;
            dspmbx_pkg::RegDscr:  res.read_data = {14'b0, dma_ctl};
            dspmbx_pkg::RegDsbl:  res.read_data = dma_size;
            dspmbx_pkg::RegCmbh:  res.read_data = cmb_hi;
            dspmbx_pkg::RegCmbl: begin
              // dsp taking the low word consumes the cpu mailbox
              res.read_data = cmb_lo;
              cmb_hi = cmb_hi & ~dspmbx_pkg::ValidBit;
            end
            dspmbx_pkg::RegDmbh:  res.read_data = dmb_hi;
            dspmbx_pkg::RegDmbl: begin
              res.read_data = dmb_lo;
              dmb_hi = dmb_hi & ~dspmbx_pkg::ValidBit;
            end
            // irq request and the accelerator data ports read as zero
            dspmbx_pkg::RegDirq, dspmbx_pkg::RegAcdat2, dspmbx_pkg::RegAcdat:
              res.read_data = '0;
            // coefficients, sinks and unknown numbers are not readable
            default: res.access_error = 1'b1;
          endcase
        end
      end
      dspmbx_pkg::OpDspWrite: begin
        if (idx >= dspmbx_pkg::RegAccFirst && idx <= dspmbx_pkg::RegAccLast) begin
          acc_regs[4'(idx - dspmbx_pkg::RegAccFirst)] = val;
        end else if (idx >= dspmbx_pkg::RegCoefFirst && idx <= dspmbx_pkg::RegCoefLast) begin
          // coefficients are write-only storage, nothing visible changes
        end else begin
          case (idx)
            dspmbx_pkg::RegDsmah: dma_main_hi = 10'(val & dspmbx_pkg::MainHighMask);
            dspmbx_pkg::RegDsmal: dma_main_lo = val & dspmbx_pkg::WordMask;
            dspmbx_pkg::RegDspa:  dma_local = val & dspmbx_pkg::HalfMask;
            dspmbx_pkg::RegDscr:  dma_ctl = val[1:0];
            dspmbx_pkg::RegDsbl: begin
              // block size write fires the dma with the freshly latched values
              dma_size = val & dspmbx_pkg::WordMask;
              res.dma_start         = 1'b1;
              res.dma_main_address  = {dma_main_hi, dma_main_lo};
              res.dma_local_address = dma_local;
              res.dma_length        = dma_size;
              res.dma_mode          = dma_ctl;
            end
            dspmbx_pkg::RegDmbh: dmb_shadow = val;
            dspmbx_pkg::RegDmbl: begin
              dmb_lo = val;
              dmb_hi = dmb_shadow | dspmbx_pkg::ValidBit;
            end
            dspmbx_pkg::RegDirq: res.cpu_interrupt = val[0];
            dspmbx_pkg::RegAcdat2, dspmbx_pkg::RegSink0, dspmbx_pkg::RegSink1: ;
            // cpu mailbox is read-only to the dsp; acdat and unknown numbers too
            default: res.access_error = 1'b1;
          endcase
        end
      end
      dspmbx_pkg::OpCpuWrMboxHi: cmb_shadow = val;
      dspmbx_pkg::OpCpuWrMboxLo: begin
        cmb_lo = val;
        cmb_hi = cmb_shadow | dspmbx_pkg::ValidBit;
      end
      dspmbx_pkg::OpCpuRdCmbHi: res.read_data = cmb_hi;
      dspmbx_pkg::OpCpuRdDmbHi: res.read_data = dmb_hi;
      dspmbx_pkg::OpCpuRdDmbLo: begin
        res.read_data = dmb_lo;
        dmb_hi = dmb_hi & ~dspmbx_pkg::ValidBit;
      end
      default: clear_page();
    endcase
    return res;
  endfunction

  // offers one access, waits for the handshake and records what it should return
  task automatic send_access(dspmbx_pkg::op_t op, logic [5:0] idx, logic [15:0] val);
    page_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, val, idx};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    res = apply_access(op, idx, val);
    owed_results.insert(owed_results.size(), res);
  endtask

  // sender stops and waits until the page owes nothing
  task automatic wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (PageLatency + 2) @(posedge clk);
  endtask

  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return dspmbx_pkg::ValidBit;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // mostly real registers, some unknown numbers
  function automatic logic [5:0] random_index();
    if ($urandom_range(0, 99) < 85) return 6'($urandom_range(0, int'(dspmbx_pkg::RegSink1)));
    return 6'($urandom_range(int'(dspmbx_pkg::RegSink1) + 1, 63));
  endfunction

  // dma register extremes, start pulse, irq request
  task automatic test_dma_and_irq();
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDsmah, 16'hffff);
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDsmal, 16'hffff);
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDspa, 16'hffff);
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDscr, 16'hffff);
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDsbl, 16'hffff);
    send_access(dspmbx_pkg::OpDspRead, dspmbx_pkg::RegDsmah, 16'h0000);
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDirq, 16'h0001);
    // bit 0 clear: no interrupt
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDirq, 16'hfffe);
    send_access(dspmbx_pkg::OpDspRead, dspmbx_pkg::RegDirq, 16'hffff);
    wait_until_drained();
  endtask

  // both mailboxes: shadow fill, valid set on low write, valid clear on low read
  task automatic test_mailboxes();
    send_access(dspmbx_pkg::OpCpuWrMboxHi, 6'd63, 16'hffff);
    send_access(dspmbx_pkg::OpCpuWrMboxLo, 6'd0, 16'h0000);
    send_access(dspmbx_pkg::OpDspRead, dspmbx_pkg::RegCmbl, 16'h0000);
    send_access(dspmbx_pkg::OpCpuRdCmbHi, 6'd21, 16'h0000);
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDmbh, 16'h1234);
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDmbl, 16'hffff);
    send_access(dspmbx_pkg::OpCpuRdDmbHi, 6'd0, 16'h0000);
    send_access(dspmbx_pkg::OpCpuRdDmbLo, 6'd0, 16'h0000);
    send_access(dspmbx_pkg::OpDspRead, dspmbx_pkg::RegDmbh, 16'h0000);
    // dsp may not write the cpu mailbox
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegCmbl, 16'hffff);
    wait_until_drained();
  endtask

  // data ports, write-only and unknown registers, the reset op
  task automatic test_reserved_and_reset();
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegAcdat, 16'hffff);
    send_access(dspmbx_pkg::OpDspRead, dspmbx_pkg::RegAcdat2, 16'h0000);
    send_access(dspmbx_pkg::OpDspRead, dspmbx_pkg::RegCoefFirst, 16'h0000);
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegSink1, 16'hffff);
    send_access(dspmbx_pkg::OpDspRead, 6'd63, 16'h0000);
    send_access(dspmbx_pkg::OpDspWrite, 6'd63, 16'hffff);
    send_access(dspmbx_pkg::OpReset, 6'd63, 16'hffff);
    // after the reset op the dma start must carry all zeros
    send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDsbl, 16'h0003);
    wait_until_drained();
  endtask

  // random accesses, with well-formed mailbox and dma sequences mixed in
  task automatic test_random_accesses(int unsigned item_total);
    int unsigned sent;
    int unsigned pick;
    dspmbx_pkg::op_t op;
    sent = 0;
    while (sent < item_total) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_access(dspmbx_pkg::OpCpuWrMboxHi, 6'($urandom_range(0, 63)), random_word());
        send_access(dspmbx_pkg::OpCpuWrMboxLo, 6'($urandom_range(0, 63)), random_word());
        send_access(dspmbx_pkg::OpDspRead, dspmbx_pkg::RegCmbh, random_word());
        send_access(dspmbx_pkg::OpDspRead, dspmbx_pkg::RegCmbl, random_word());
        send_access(dspmbx_pkg::OpCpuRdCmbHi, 6'($urandom_range(0, 63)), random_word());
        sent += 5;
      end else if (pick < 20) begin
        send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDmbh, random_word());
        send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDmbl, random_word());
        send_access(dspmbx_pkg::OpCpuRdDmbHi, 6'($urandom_range(0, 63)), random_word());
        send_access(dspmbx_pkg::OpCpuRdDmbLo, 6'($urandom_range(0, 63)), random_word());
        send_access(dspmbx_pkg::OpCpuRdDmbHi, 6'($urandom_range(0, 63)), random_word());
        sent += 5;
      end else if (pick < 30) begin
        send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDsmah, random_word());
        send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDsmal, random_word());
        send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDspa, random_word());
        send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDscr, random_word());
        send_access(dspmbx_pkg::OpDspWrite, dspmbx_pkg::RegDsbl, random_word());
        sent += 5;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 2) op = dspmbx_pkg::OpReset;
        else if (pick < 50) op = dspmbx_pkg::OpDspWrite;
        else if (pick < 75) op = dspmbx_pkg::OpDspRead;
        else op = dspmbx_pkg::op_t'($urandom_range(int'(dspmbx_pkg::OpCpuWrMboxHi),
                                                   int'(dspmbx_pkg::OpCpuRdDmbLo)));
        send_access(op, random_index(), random_word());
        sent++;
      end
    end
    wait_until_drained();
  endtask

  task automatic compare_field(string field_name, logic [25:0] want, logic [25:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field_name, want, got);
      mismatch_count++;
    end
  endtask

  // receiver: random stalls at the configured odds
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // every accepted result beat against the oldest owed result
  always @(posedge clk) begin
    page_result_t got;
    page_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[78:0];
      if (owed_results.size() == 0) begin
        $error("result beat with nothing owed: 0x%0h", m_axis_tdata);
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        compare_field("read_data", 26'(want.read_data), 26'(got.read_data));
        compare_field("access_error", 26'(want.access_error), 26'(got.access_error));
        compare_field("dma_start", 26'(want.dma_start), 26'(got.dma_start));
        compare_field("dma_main_address", want.dma_main_address, got.dma_main_address);
        compare_field("dma_local_address", 26'(want.dma_local_address),
                      26'(got.dma_local_address));
        compare_field("dma_length", 26'(want.dma_length), 26'(got.dma_length));
        compare_field("dma_mode", 26'(want.dma_mode), 26'(got.dma_mode));
        compare_field("cpu_interrupt", 26'(want.cpu_interrupt), 26'(got.cpu_interrupt));
      end
    end
  end

  initial begin
    clear_page();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_dma_and_irq();
    test_mailboxes();
    test_reserved_and_reset();

    // random part in four idling phases, drained in between
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_accesses(225);
    send_idle_pct = 62;
    recv_stall_pct = 0;
    test_random_accesses(225);
    send_idle_pct = 0;
    recv_stall_pct = 62;
    test_random_accesses(225);
    send_idle_pct = 13;
    recv_stall_pct = 13;
    test_random_accesses(225);

    repeat (PageLatency + 8) @(posedge clk);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
